FILE: sv/pbss_pkg.sv
// ----------------------------------------------------------------------------
// pbss_pkg
// Types, codes and constants shared by the BAR sizing sequencer files.
// ----------------------------------------------------------------------------
package pbss_pkg;

  localparam int unsigned MaxBarsDefault = 6;

  // Command codes on the input channel
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_RESP  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_RECORD = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  // Completion status
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_INVALID     = 3'd1;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd2;
  localparam logic [2:0] ST_PROTOCOL    = 3'd3;
  localparam logic [2:0] ST_ACCESS      = 3'd4;

  // Header layouts
  localparam logic [6:0] LAYOUT_DEVICE = 7'd0;
  localparam logic [6:0] LAYOUT_BRIDGE = 7'd1;

  // Config space offsets
  localparam logic [7:0] OFF_COMMAND = 8'h04;
  localparam logic [7:0] OFF_BAR0    = 8'h10;

  localparam logic [31:0] CMD_DECODE_CLEAR = 32'h0000_fffc;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  bus_number;
    logic [4:0]  device_number;
    logic [2:0]  func_number;
    logic [15:0] segment_number;
    logic [7:0]  header_kind;
    logic [31:0] resp_data;
    logic        resp_error;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] cfg_address;
    logic [31:0] write_data;
    logic [2:0]  bar_slot;
    logic [63:0] bar_address;
    logic [63:0] bar_size;
    logic        bar_is_memory;
    logic        bar_is_wide;
    logic        bar_prefetch;
    logic [2:0]  status;
    logic        last;
  } result_t;

endpackage

FILE: sv/pbss_if.sv
// ----------------------------------------------------------------------------
// pbss_in_if / pbss_out_if
// Valid/ready channels for start and response items and for result items.
// ----------------------------------------------------------------------------
interface pbss_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  bus_number;
  logic [4:0]  device_number;
  logic [2:0]  func_number;
  logic [15:0] segment_number;
  logic [7:0]  header_kind;
  logic [31:0] resp_data;
  logic        resp_error;

  modport source (output valid, cmd, bus_number, device_number, func_number,
                  segment_number, header_kind, resp_data, resp_error,
                  input ready);
  modport sink (input valid, cmd, bus_number, device_number, func_number,
                segment_number, header_kind, resp_data, resp_error,
                output ready);
endinterface

interface pbss_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] cfg_address;
  logic [31:0] write_data;
  logic [2:0]  bar_slot;
  logic [63:0] bar_address;
  logic [63:0] bar_size;
  logic        bar_is_memory;
  logic        bar_is_wide;
  logic        bar_prefetch;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, kind, cfg_address, write_data, bar_slot,
                  bar_address, bar_size, bar_is_memory, bar_is_wide,
                  bar_prefetch, status, last, input ready);
  modport sink (input valid, kind, cfg_address, write_data, bar_slot,
                bar_address, bar_size, bar_is_memory, bar_is_wide,
                bar_prefetch, status, last, output ready);
endinterface

FILE: sv/pci_bar_sizing_sequencer.sv
// ----------------------------------------------------------------------------
// pci_bar_sizing_sequencer
// Sizes the BARs of one PCI function through a config access request stream.
// ----------------------------------------------------------------------------
// Each start item or access response that is taken yields at most
// two results (a BAR record and the next request or done), which pass
// through a three-entry result queue. The input is ready while the queue
// holds at most one result, so with the output drained every cycle one item
// is accepted per cycle while each step yields one result; a step that
// yields two results holds the input off until the queue holds one again.
module pci_bar_sizing_sequencer #(
  parameter int unsigned MAX_BARS = pbss_pkg::MaxBarsDefault
) (
  input logic       clk,
  input logic       rst,
  pbss_in_if.sink   in_ch,
  pbss_out_if.source out_ch
);
  import pbss_pkg::*;

  item_t      item;
  logic       take;
  logic [1:0] res_count;
  result_t    res0, res1;

  result_t    queue [3];
  logic [1:0] head, tail, count, count_next;
  logic       pop;

  function automatic logic [1:0] step3(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  assign item = '{cmd: in_ch.cmd, bus_number: in_ch.bus_number,
                  device_number: in_ch.device_number, func_number: in_ch.func_number,
                  segment_number: in_ch.segment_number, header_kind: in_ch.header_kind,
                  resp_data: in_ch.resp_data, resp_error: in_ch.resp_error};

  assign in_ch.ready = (count <= 2'd1);
  assign take = in_ch.valid && in_ch.ready;
  assign pop = out_ch.valid && out_ch.ready;

  pbss_seq #(.MAX_BARS(MAX_BARS)) u_seq (
    .clk(clk), .rst(rst), .take(take), .item(item),
    .res_count(res_count), .res0(res0), .res1(res1)
  );

  assign count_next = count + res_count - {1'b0, pop};

  // Push new results at the tail, drop the taken one at the head
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) head <= step3(head);
      if (res_count == 2'd1) tail <= step3(tail);
      if (res_count == 2'd2) tail <= step3(step3(tail));
    end
  end

  always_ff @(posedge clk) begin
    if (res_count != 2'd0) queue[tail] <= res0;
    if (res_count == 2'd2) queue[step3(tail)] <= res1;
  end

  // Drive the output from the head entry
  assign out_ch.valid         = (count != 2'd0);
  assign out_ch.kind          = queue[head].kind;
  assign out_ch.cfg_address   = queue[head].cfg_address;
  assign out_ch.write_data    = queue[head].write_data;
  assign out_ch.bar_slot      = queue[head].bar_slot;
  assign out_ch.bar_address   = queue[head].bar_address;
  assign out_ch.bar_size      = queue[head].bar_size;
  assign out_ch.bar_is_memory = queue[head].bar_is_memory;
  assign out_ch.bar_is_wide   = queue[head].bar_is_wide;
  assign out_ch.bar_prefetch  = queue[head].bar_prefetch;
  assign out_ch.status        = queue[head].status;
  assign out_ch.last          = queue[head].last;

endmodule

FILE: sv/pbss_seq.sv
// ----------------------------------------------------------------------------
// pbss_seq
// Probe state and next-step logic: one accepted item yields up to two results.
// ----------------------------------------------------------------------------
module pbss_seq #(
  parameter int unsigned MAX_BARS = pbss_pkg::MaxBarsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  pbss_pkg::item_t  item,
  output logic [1:0]       res_count,
  output pbss_pkg::result_t res0,
  output pbss_pkg::result_t res1
);
  import pbss_pkg::*;

  typedef enum logic [13:0] {
    PH_IDLE        = 14'b00000000000001,
    PH_CMD_READ    = 14'b00000000000010,
    PH_CMD_CLEAR   = 14'b00000000000100,
    PH_LOW_READ    = 14'b00000000001000,
    PH_HIGH_READ   = 14'b00000000010000,
    PH_ONES_LOW    = 14'b00000000100000,
    PH_ONES_HIGH   = 14'b00000001000000,
    PH_MASK_LOW    = 14'b00000010000000,
    PH_MASK_HIGH   = 14'b00000100000000,
    PH_REST_LOW32  = 14'b00001000000000,
    PH_REST_LOW64  = 14'b00010000000000,
    PH_REST_HIGH64 = 14'b00100000000000,
    PH_REST_ABORT  = 14'b01000000000000,
    PH_CMD_RESTORE = 14'b10000000000000
  } phase_t;

  localparam logic [2:0] SlotsDevice = 3'(MAX_BARS);
  localparam logic [2:0] SlotsBridge = 3'd2;

  phase_t      phase, phase_next;
  logic [15:0] target_id, target_id_next;
  logic [2:0]  slot_index, slot_index_next;
  logic [2:0]  slot_count, slot_count_next;
  logic [31:0] saved_command, saved_command_next;
  logic [31:0] orig_low, orig_low_next;
  logic [31:0] orig_high, orig_high_next;
  logic [31:0] mask_low_word, mask_low_next;
  logic [31:0] mask_high_word, mask_high_next;
  logic [2:0]  probe_status, probe_status_next;

  // Action of this step: one request or a done
  logic        act_en, rec_en;
  logic [1:0]  act_kind;
  logic [7:0]  act_off;
  logic [31:0] act_data;
  logic [2:0]  act_status;
  result_t     act, rec;

  // Region decode
  logic [7:0]  bar_off;
  logic        is_wide;
  logic [63:0] am64, size64, addr64;
  logic [31:0] am32, size32, addr32, amio, sizeio;
  logic        bad64, bad32;

  assign bar_off = OFF_BAR0 + {3'b000, slot_index, 2'b00};
  assign is_wide = (orig_low[2:0] == 3'b100);

  // A zero address mask gives a zero size, which is never a valid region
  assign am64   = {mask_high_word, mask_low_word[31:4], 4'b0000};
  assign size64 = ~am64 + 64'd1;
  assign addr64 = {orig_high, orig_low[31:4], 4'b0000};
  assign bad64  = (am64 == '0) || ((size64 & ~am64) != '0) || ((addr64 & ~am64) != '0);

  assign am32   = {mask_low_word[31:4], 4'b0000};
  assign size32 = ~am32 + 32'd1;
  assign addr32 = {orig_low[31:4], 4'b0000};
  assign bad32  = (am32 == '0) || ((size32 & ~am32) != '0) || ((addr32 & ~am32) != '0);

  assign amio   = {mask_low_word[31:2], 2'b00};
  assign sizeio = ~amio + 32'd1;

  always_comb begin
    phase_next         = phase;
    target_id_next     = target_id;
    slot_index_next    = slot_index;
    slot_count_next    = slot_count;
    saved_command_next = saved_command;
    orig_low_next      = orig_low;
    orig_high_next     = orig_high;
    mask_low_next      = mask_low_word;
    mask_high_next     = mask_high_word;
    probe_status_next  = probe_status;
    act_en     = 1'b0;
    act_kind   = KIND_READ;
    act_off    = OFF_COMMAND;
    act_data   = '0;
    act_status = ST_OK;
    rec_en     = 1'b0;
    rec        = '0;

    if (take) begin
      if (item.cmd == CMD_START) begin
        if (phase == PH_IDLE) begin
          act_en = 1'b1;
          priority if (item.header_kind[6:0] != LAYOUT_DEVICE &&
                       item.header_kind[6:0] != LAYOUT_BRIDGE) begin
            act_kind = KIND_DONE;
            act_status = ST_UNSUPPORTED;
          end else begin
            slot_count_next = (item.header_kind[6:0] == LAYOUT_DEVICE) ? SlotsDevice
                                                                       : SlotsBridge;
            if (item.segment_number != '0) begin
              act_kind = KIND_DONE;
              act_status = ST_INVALID;
            end else begin
              target_id_next = {item.bus_number, item.device_number, item.func_number};
              slot_index_next = '0;
              probe_status_next = ST_OK;
              act_kind = KIND_READ;
              act_off = OFF_COMMAND;
              phase_next = PH_CMD_READ;
            end
          end
        end
      end else begin
        unique case (phase)
          PH_CMD_READ: begin
            act_en = 1'b1;
            if (item.resp_error) begin
              act_kind = KIND_DONE;
              act_status = ST_ACCESS;
            end else begin
              saved_command_next = item.resp_data;
              act_kind = KIND_WRITE;
              act_data = item.resp_data & CMD_DECODE_CLEAR;
              phase_next = PH_CMD_CLEAR;
            end
          end
          PH_CMD_CLEAR: begin
            act_en = 1'b1;
            if (item.resp_error) begin
              act_kind = KIND_DONE;
              act_status = ST_ACCESS;
            end else begin
              slot_index_next = '0;
              phase_next = PH_LOW_READ;
              act_off = OFF_BAR0;
            end
          end
          PH_LOW_READ: begin
            act_en = 1'b1;
            if (item.resp_error) begin
              probe_status_next = ST_ACCESS;
              phase_next = PH_CMD_RESTORE;
            end else begin
              orig_low_next = item.resp_data;
              priority if (!item.resp_data[0] && item.resp_data[2:1] != 2'b00 &&
                           item.resp_data[2:1] != 2'b10) begin
                probe_status_next = ST_PROTOCOL;
                phase_next = PH_CMD_RESTORE;
              end else if (!item.resp_data[0] && item.resp_data[2:1] == 2'b10) begin
                if ({1'b0, slot_index} + 4'd1 >= {1'b0, slot_count}) begin
                  probe_status_next = ST_PROTOCOL;
                  phase_next = PH_CMD_RESTORE;
                end else begin
                  act_off = bar_off + 8'd4;
                  phase_next = PH_HIGH_READ;
                end
              end else begin
                act_kind = KIND_WRITE;
                act_off = bar_off;
                act_data = '1;
                phase_next = PH_ONES_LOW;
              end
            end
          end
          PH_HIGH_READ: begin
            act_en = 1'b1;
            if (item.resp_error) begin
              probe_status_next = ST_ACCESS;
              phase_next = PH_CMD_RESTORE;
            end else begin
              orig_high_next = item.resp_data;
              act_kind = KIND_WRITE;
              act_off = bar_off;
              act_data = '1;
              phase_next = PH_ONES_LOW;
            end
          end
          PH_ONES_LOW: begin
            act_en = 1'b1;
            if (item.resp_error) begin
              probe_status_next = ST_ACCESS;
              phase_next = PH_CMD_RESTORE;
            end else if (is_wide) begin
              act_kind = KIND_WRITE;
              act_off = bar_off + 8'd4;
              act_data = '1;
              phase_next = PH_ONES_HIGH;
            end else begin
              act_off = bar_off;
              phase_next = PH_MASK_LOW;
            end
          end
          PH_ONES_HIGH: begin
            act_en = 1'b1;
            if (item.resp_error) begin
              probe_status_next = ST_ACCESS;
              act_kind = KIND_WRITE;
              act_off = bar_off;
              act_data = orig_low;
              phase_next = PH_REST_ABORT;
            end else begin
              act_off = bar_off;
              phase_next = PH_MASK_LOW;
            end
          end
          PH_MASK_LOW: begin
            act_en = 1'b1;
            mask_low_next = item.resp_data;
            if (item.resp_error) probe_status_next = ST_ACCESS;
            act_kind = KIND_WRITE;
            act_off = bar_off;
            act_data = orig_low;
            if (is_wide && !item.resp_error) begin
              act_kind = KIND_READ;
              act_off = bar_off + 8'd4;
              act_data = '0;
              phase_next = PH_MASK_HIGH;
            end else if (is_wide) begin
              phase_next = PH_REST_LOW64;
            end else begin
              phase_next = PH_REST_LOW32;
            end
          end
          PH_MASK_HIGH: begin
            act_en = 1'b1;
            mask_high_next = item.resp_data;
            if (item.resp_error) probe_status_next = ST_ACCESS;
            act_kind = KIND_WRITE;
            act_off = bar_off;
            act_data = orig_low;
            phase_next = PH_REST_LOW64;
          end
          PH_REST_LOW64: begin
            act_en = 1'b1;
            act_kind = KIND_WRITE;
            act_off = bar_off + 8'd4;
            act_data = orig_high;
            phase_next = PH_REST_HIGH64;
          end
          PH_REST_ABORT: begin
            act_en = 1'b1;
            probe_status_next = ST_ACCESS;
            phase_next = PH_CMD_RESTORE;
          end
          PH_REST_HIGH64: begin
            act_en = 1'b1;
            if (probe_status != ST_OK) begin
              phase_next = PH_CMD_RESTORE;
            end else if (((mask_low_word == '0) && (mask_high_word == '0)) ||
                         ((&mask_low_word) && (&mask_high_word))) begin
              slot_index_next = slot_index + 3'd2;
              phase_next = PH_LOW_READ;
            end else if (bad64) begin
              probe_status_next = ST_PROTOCOL;
              phase_next = PH_CMD_RESTORE;
            end else begin
              rec_en = 1'b1;
              rec.kind = KIND_RECORD;
              rec.bar_slot = slot_index;
              rec.bar_address = addr64;
              rec.bar_size = size64;
              rec.bar_is_memory = 1'b1;
              rec.bar_is_wide = 1'b1;
              rec.bar_prefetch = orig_low[3];
              slot_index_next = slot_index + 3'd2;
              phase_next = PH_LOW_READ;
            end
          end
          PH_REST_LOW32: begin
            act_en = 1'b1;
            if (probe_status != ST_OK) begin
              phase_next = PH_CMD_RESTORE;
            end else if ((mask_low_word == '0) || (&mask_low_word)) begin
              slot_index_next = slot_index + 3'd1;
              phase_next = PH_LOW_READ;
            end else if (orig_low[0]) begin
              rec_en = 1'b1;
              rec.kind = KIND_RECORD;
              rec.bar_slot = slot_index;
              rec.bar_address = {32'd0, orig_low[31:2], 2'b00};
              rec.bar_size = {32'd0, sizeio};
              slot_index_next = slot_index + 3'd1;
              phase_next = PH_LOW_READ;
            end else if (bad32) begin
              probe_status_next = ST_PROTOCOL;
              phase_next = PH_CMD_RESTORE;
            end else begin
              rec_en = 1'b1;
              rec.kind = KIND_RECORD;
              rec.bar_slot = slot_index;
              rec.bar_address = {32'd0, addr32};
              rec.bar_size = {32'd0, size32};
              rec.bar_is_memory = 1'b1;
              rec.bar_prefetch = orig_low[3];
              slot_index_next = slot_index + 3'd1;
              phase_next = PH_LOW_READ;
            end
          end
          PH_CMD_RESTORE: begin
            act_en = 1'b1;
            act_kind = KIND_DONE;
            act_status = (probe_status == ST_OK && item.resp_error) ? ST_ACCESS
                                                                    : probe_status;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase

        // Advance to the next BAR, or restore the command once all are done
        if (phase_next == PH_LOW_READ && phase != PH_LOW_READ) begin
          if (slot_index_next < slot_count) begin
            act_kind = KIND_READ;
            act_off = OFF_BAR0 + {3'b000, slot_index_next, 2'b00};
            act_data = '0;
          end else begin
            probe_status_next = ST_OK;
            phase_next = PH_CMD_RESTORE;
          end
        end
        // Entering the restore issues the command write
        if (phase_next == PH_CMD_RESTORE && phase != PH_CMD_RESTORE) begin
          act_kind = KIND_WRITE;
          act_off = OFF_COMMAND;
          act_data = {16'd0, saved_command[15:0]};
        end
      end
      if (act_en && act_kind == KIND_DONE) phase_next = PH_IDLE;
    end
  end

  // Form the two results
  always_comb begin
    act = '0;
    act.kind = act_kind;
    if (act_kind == KIND_DONE) begin
      act.status = act_status;
    end else begin
      act.cfg_address = {1'b1, 7'd0, target_id_next, act_off[7:2], 2'b00};
      act.write_data = act_data;
    end
    act.last = 1'b1;
    res0 = rec_en ? rec : act;
    res1 = act;
    res_count = act_en ? (rec_en ? 2'd2 : 2'd1) : 2'd0;
  end

  // Hold probe state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      target_id <= '0;
      slot_index <= '0;
      slot_count <= '0;
      saved_command <= '0;
      orig_low <= '0;
      orig_high <= '0;
      mask_low_word <= '0;
      mask_high_word <= '0;
      probe_status <= ST_OK;
    end else begin
      phase <= phase_next;
      target_id <= target_id_next;
      slot_index <= slot_index_next;
      slot_count <= slot_count_next;
      saved_command <= saved_command_next;
      orig_low <= orig_low_next;
      orig_high <= orig_high_next;
      mask_low_word <= mask_low_next;
      mask_high_word <= mask_high_next;
      probe_status <= probe_status_next;
    end
  end

endmodule

FILE: tb/sv/pci_bar_sizing_sequencer_tb.sv
// ----------------------------------------------------------------------------
// pci_bar_sizing_sequencer_tb
// Plays the config space of one PCI function behind the BAR sizing sequencer:
// answers each access from a per-probe plan of BARs and checks every request,
// BAR record and completion against an in-bench prediction of the sequence.
// ----------------------------------------------------------------------------
module pci_bar_sizing_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pbss_pkg::*;

  localparam int NoAcceptLimit = 5000;
  localparam int HoldOffCycles = 300;

  typedef enum logic [3:0] {
    PH_IDLE, PH_CMD_RD, PH_CMD_CLR, PH_LOW_RD, PH_HIGH_RD, PH_ONES_LO, PH_ONES_HI,
    PH_MASK_LO, PH_MASK_HI, PH_REST_LO32, PH_REST_LO64, PH_REST_HI64, PH_REST_ABORT,
    PH_CMD_REST
  } probe_ph_t;

  typedef enum logic [2:0] {
    BP_UNUSED, BP_IO, BP_MEM32, BP_MEM64, BP_RESERVED, BP_BADSIZE, BP_MISALIGN,
    BP_UNUSED64
  } bar_plan_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pbss_in_if  in_ch ();
  pbss_out_if out_ch ();

  pci_bar_sizing_sequencer dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Predicted sequencer state
  probe_ph_t   ph = PH_IDLE;
  logic [7:0]  tgt_bus = '0;
  logic [4:0]  tgt_dev = '0;
  logic [2:0]  tgt_fn = '0;
  logic [2:0]  slot = '0;
  logic [2:0]  slot_cnt = '0;
  logic [31:0] saved_cmd = '0;
  logic [31:0] orig_lo = '0;
  logic [31:0] orig_hi = '0;
  logic [31:0] mask_lo = '0;
  logic [31:0] mask_hi = '0;
  logic [2:0]  probe_st = ST_OK;

  result_t step_q[$];
  result_t access_q[$];

  // Config space plan of the probed function
  bar_plan_t   plan_kind[6];
  logic [63:0] plan_addr[6];
  logic [63:0] plan_size[6];
  logic        plan_pf[6];
  logic        plan_ones[6];

  int        errors = 0;
  int        item_count = 0;
  int        src_idle_pct = 0;
  int        snk_stall_pct = 0;
  int        err_pct = 0;
  probe_ph_t err_phase = PH_IDLE;
  int        hold_req = 0;
  int        hold_left = 0;
  int        quiet_cycles = 0;

  function automatic logic [7:0] bar_off();
    return OFF_BAR0 + 8'(4 * slot);
  endfunction

  function automatic void emit_req(logic [1:0] k, logic [7:0] off, logic [31:0] d);
    result_t r;
    r = '0;
    r.kind = k;
    r.cfg_address = 32'h8000_0000 | {8'h0, tgt_bus, 16'h0} | {16'h0, tgt_dev, 11'h0}
                  | {21'h0, tgt_fn, 8'h0} | {24'h0, off & 8'hfc};
    r.write_data = d;
    step_q.push_back(r);
  endfunction

  function automatic void emit_done(logic [2:0] st);
    result_t r;
    r = '0;
    r.kind = KIND_DONE;
    r.status = st;
    step_q.push_back(r);
    ph = PH_IDLE;
  endfunction

  function automatic void emit_finish(logic [2:0] st);
    probe_st = st;
    emit_req(KIND_WRITE, OFF_COMMAND, saved_cmd & 32'h0000_ffff);
    ph = PH_CMD_REST;
  endfunction

  function automatic void emit_record(logic [63:0] a, logic [63:0] s, logic mem, logic wide,
                                      logic pf);
    result_t r;
    r = '0;
    r.kind = KIND_RECORD;
    r.bar_slot = slot;
    r.bar_address = a;
    r.bar_size = s;
    r.bar_is_memory = mem;
    r.bar_is_wide = wide;
    r.bar_prefetch = pf;
    step_q.push_back(r);
  endfunction

  function automatic void next_slot();
    if (slot < slot_cnt) begin
      emit_req(KIND_READ, bar_off(), '0);
      ph = PH_LOW_RD;
    end else begin
      emit_finish(ST_OK);
    end
  endfunction

  function automatic logic bad_region(logic [63:0] a, logic [63:0] s);
    return s == 0 || (s & (s - 1)) != 0 || (a & (s - 1)) != 0;
  endfunction

  // Work out the results of one accepted request and queue them
  function automatic void predict_step(item_t it);
    logic [31:0] d;
    logic        e;
    logic [6:0]  lay;
    logic [63:0] am, sz, ad;
    logic [31:0] am32, sz32, ad32;
    d = it.resp_data;
    e = it.resp_error;
    lay = it.header_kind[6:0];
    step_q = {};
    if (it.cmd == CMD_START) begin
      if (ph == PH_IDLE) begin
        if (lay == LAYOUT_DEVICE) slot_cnt = 3'(MaxBarsDefault);
        else if (lay == LAYOUT_BRIDGE) slot_cnt = 3'd2;
        if (lay != LAYOUT_DEVICE && lay != LAYOUT_BRIDGE) begin
          emit_done(ST_UNSUPPORTED);
        end else if (it.segment_number != 0) begin
          emit_done(ST_INVALID);
        end else begin
          tgt_bus = it.bus_number;
          tgt_dev = it.device_number;
          tgt_fn = it.func_number;
          slot = 0;
          probe_st = ST_OK;
          emit_req(KIND_READ, OFF_COMMAND, '0);
          ph = PH_CMD_RD;
        end
      end
    end else begin
      case (ph)
        PH_CMD_RD: begin
          if (e) emit_done(ST_ACCESS);
          else begin
            saved_cmd = d;
            emit_req(KIND_WRITE, OFF_COMMAND, d & CMD_DECODE_CLEAR);
            ph = PH_CMD_CLR;
          end
        end
        PH_CMD_CLR: begin
          if (e) emit_done(ST_ACCESS);
          else begin
            slot = 0;
            next_slot();
          end
        end
        PH_LOW_RD: begin
          if (e) emit_finish(ST_ACCESS);
          else begin
            orig_lo = d;
            if (!d[0] && d[2:1] != 2'b00 && d[2:1] != 2'b10) begin
              emit_finish(ST_PROTOCOL);
            end else if (!d[0] && d[2:1] == 2'b10) begin
              if (4'(slot) + 1 >= 4'(slot_cnt)) emit_finish(ST_PROTOCOL);
              else begin
                emit_req(KIND_READ, bar_off() + 8'd4, '0);
                ph = PH_HIGH_RD;
              end
            end else begin
              emit_req(KIND_WRITE, bar_off(), '1);
              ph = PH_ONES_LO;
            end
          end
        end
        PH_HIGH_RD: begin
          if (e) emit_finish(ST_ACCESS);
          else begin
            orig_hi = d;
            emit_req(KIND_WRITE, bar_off(), '1);
            ph = PH_ONES_LO;
          end
        end
        PH_ONES_LO: begin
          if (e) emit_finish(ST_ACCESS);
          else if (orig_lo[2:0] == 3'b100) begin
            emit_req(KIND_WRITE, bar_off() + 8'd4, '1);
            ph = PH_ONES_HI;
          end else begin
            emit_req(KIND_READ, bar_off(), '0);
            ph = PH_MASK_LO;
          end
        end
        PH_ONES_HI: begin
          if (e) begin
            probe_st = ST_ACCESS;
            emit_req(KIND_WRITE, bar_off(), orig_lo);
            ph = PH_REST_ABORT;
          end else begin
            emit_req(KIND_READ, bar_off(), '0);
            ph = PH_MASK_LO;
          end
        end
        PH_MASK_LO: begin
          mask_lo = d;
          if (e) probe_st = ST_ACCESS;
          if (orig_lo[2:0] == 3'b100 && !e) begin
            emit_req(KIND_READ, bar_off() + 8'd4, '0);
            ph = PH_MASK_HI;
          end else begin
            emit_req(KIND_WRITE, bar_off(), orig_lo);
            ph = (orig_lo[2:0] == 3'b100) ? PH_REST_LO64 : PH_REST_LO32;
          end
        end
        PH_MASK_HI: begin
          mask_hi = d;
          if (e) probe_st = ST_ACCESS;
          emit_req(KIND_WRITE, bar_off(), orig_lo);
          ph = PH_REST_LO64;
        end
        PH_REST_LO64: begin
          emit_req(KIND_WRITE, bar_off() + 8'd4, orig_hi);
          ph = PH_REST_HI64;
        end
        PH_REST_ABORT: emit_finish(ST_ACCESS);
        PH_REST_HI64: begin
          if (probe_st != ST_OK) emit_finish(probe_st);
          else if ((mask_lo == 0 && mask_hi == 0) || (mask_lo == '1 && mask_hi == '1)) begin
            slot = slot + 3'd2;
            next_slot();
          end else begin
            am = {mask_hi, mask_lo & ~32'hf};
            sz = ~am + 1;
            ad = {orig_hi, orig_lo & ~32'hf};
            if (bad_region(ad, sz)) emit_finish(ST_PROTOCOL);
            else begin
              emit_record(ad, sz, 1'b1, 1'b1, orig_lo[3]);
              slot = slot + 3'd2;
              next_slot();
            end
          end
        end
        PH_REST_LO32: begin
          if (probe_st != ST_OK) emit_finish(probe_st);
          else if (mask_lo == 0 || mask_lo == '1) begin
            slot = slot + 3'd1;
            next_slot();
          end else if (orig_lo[0]) begin
            am32 = mask_lo & ~32'h3;
            sz32 = ~am32 + 1;
            ad32 = orig_lo & ~32'h3;
            emit_record({32'h0, ad32}, {32'h0, sz32}, 1'b0, 1'b0, 1'b0);
            slot = slot + 3'd1;
            next_slot();
          end else begin
            am32 = mask_lo & ~32'hf;
            sz32 = ~am32 + 1;
            ad32 = orig_lo & ~32'hf;
            if (bad_region({32'h0, ad32}, {32'h0, sz32})) emit_finish(ST_PROTOCOL);
            else begin
              emit_record({32'h0, ad32}, {32'h0, sz32}, 1'b1, 1'b0, orig_lo[3]);
              slot = slot + 3'd1;
              next_slot();
            end
          end
        end
        PH_CMD_REST: emit_done((probe_st == ST_OK && e) ? ST_ACCESS : probe_st);
        default: ph = PH_IDLE;
      endcase
    end
    // Mark the final result of this request and hand all of them over
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) access_q.push_back(step_q[i]);
  endfunction

  // Draw a random BAR layout for the next probe
  task automatic make_plan();
    int pick, lg;
    for (int s = 0; s < 6; s++) begin
      pick = $urandom_range(0, 99);
      plan_pf[s] = 1'($urandom_range(0, 1));
      plan_ones[s] = 1'($urandom_range(0, 1));
      if (pick < 14) plan_kind[s] = BP_UNUSED;
      else if (pick < 34) plan_kind[s] = BP_IO;
      else if (pick < 58) plan_kind[s] = BP_MEM32;
      else if (pick < 78) plan_kind[s] = BP_MEM64;
      else if (pick < 82) plan_kind[s] = BP_RESERVED;
      else if (pick < 86) plan_kind[s] = BP_BADSIZE;
      else if (pick < 90) plan_kind[s] = BP_MISALIGN;
      else plan_kind[s] = BP_UNUSED64;
      case (plan_kind[s])
        BP_IO: lg = $urandom_range(2, 8);
        BP_MEM32: lg = $urandom_range(4, 31);
        BP_MEM64: lg = ($urandom_range(0, 9) == 0) ? 63 : $urandom_range(4, 40);
        BP_MISALIGN: lg = $urandom_range(5, 20);
        default: lg = $urandom_range(4, 12);
      endcase
      plan_size[s] = 64'd1 << lg;
      plan_addr[s] = {$urandom, $urandom} & ~(plan_size[s] - 1);
      if (plan_kind[s] != BP_MEM64) plan_addr[s][63:32] = '0;
      if (plan_kind[s] == BP_MISALIGN) plan_addr[s] = plan_addr[s] | (plan_size[s] >> 1);
    end
  endtask

  // Answer the access that the sequencer is waiting on
  function automatic logic [31:0] config_word();
    logic [31:0] d, m;
    logic [63:0] m64;
    logic [3:0]  tbits;
    bar_plan_t   k;
    k = plan_kind[slot];
    d = $urandom;
    m = ~(plan_size[slot][31:0] - 1);
    m64 = ~(plan_size[slot] - 64'd1);
    tbits = {plan_pf[slot], (k == BP_MEM64 || k == BP_UNUSED64) ? 3'b100 : 3'b000};
    case (ph)
      PH_LOW_RD: begin
        case (k)
          BP_UNUSED: d = '0;
          BP_IO: d = plan_addr[slot][31:0] | 32'h1;
          BP_RESERVED: d = (d & ~32'h7) | ($urandom_range(0, 1) ? 32'h2 : 32'h6);
          default: d = (plan_addr[slot][31:0] & ~32'hf) | {28'h0, tbits};
        endcase
      end
      PH_HIGH_RD: d = plan_addr[slot][63:32];
      PH_MASK_LO: begin
        case (k)
          BP_UNUSED, BP_UNUSED64: d = plan_ones[slot] ? '1 : '0;
          BP_IO: d = m | 32'h1;
          BP_BADSIZE: d = ((m ^ 32'h0001_0000) & ~32'hf) | {28'h0, tbits};
          default: d = (m & ~32'hf) | {28'h0, tbits};
        endcase
      end
      PH_MASK_HI: begin
        if (k == BP_UNUSED64) d = plan_ones[slot] ? '1 : '0;
        else d = m64[63:32];
      end
      default: ;
    endcase
    return d;
  endfunction

  // Offer one request and wait until the sequencer takes it
  task automatic send_request(item_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.cmd = it.cmd;
    in_ch.bus_number = it.bus_number;
    in_ch.device_number = it.device_number;
    in_ch.func_number = it.func_number;
    in_ch.segment_number = it.segment_number;
    in_ch.header_kind = it.header_kind;
    in_ch.resp_data = it.resp_data;
    in_ch.resp_error = it.resp_error;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_step(it);
    item_count++;
    @(negedge clk);
  endtask

  function automatic item_t noise_item(logic c);
    item_t       it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    it.cmd = c;
    it.resp_error = 1'b0;
    return it;
  endfunction

  // Run one probe from start to completion, answering every access
  task automatic run_probe(logic [7:0] bus, logic [4:0] dev, logic [2:0] fn,
                           logic [15:0] seg, logic [7:0] hdr, logic busy_start);
    item_t it;
    it = noise_item(CMD_START);
    it.bus_number = bus;
    it.device_number = dev;
    it.func_number = fn;
    it.segment_number = seg;
    it.header_kind = hdr;
    send_request(it);
    while (ph != PH_IDLE) begin
      it = noise_item(CMD_RESP);
      it.resp_data = config_word();
      it.resp_error = (ph == err_phase) || ($urandom_range(0, 99) < err_pct);
      send_request(it);
      // A start while a probe runs is dropped
      if (busy_start && ph != PH_IDLE) begin
        send_request(noise_item(CMD_START));
        busy_start = 1'b0;
      end
    end
  endtask

  task automatic test_directed();
    err_pct = 0;
    // Unknown layout, nonzero segment, response while idle
    run_probe(8'hff, 5'h1f, 3'h7, 16'h0000, 8'hff, 1'b0);
    run_probe(8'h00, 5'h00, 3'h0, 16'hffff, 8'h80, 1'b0);
    send_request(noise_item(CMD_RESP));
    // Command read fails
    err_phase = PH_CMD_RD;
    run_probe(8'h12, 5'h03, 3'h1, 16'h0, 8'h00, 1'b0);
    // Bridge with a 64-bit BAR whose second all-ones write fails
    plan_kind[0] = BP_MEM64;
    plan_size[0] = 64'h1_0000_0000;
    plan_addr[0] = 64'hffff_ffff_0000_0000;
    plan_pf[0] = 1'b1;
    err_phase = PH_ONES_HI;
    run_probe(8'hff, 5'h1f, 3'h7, 16'h0, 8'h81, 1'b1);
    // Bridge with an I/O BAR and a memory BAR, command restore fails
    plan_kind[0] = BP_IO;
    plan_size[0] = 64'h4;
    plan_addr[0] = 64'hffff_fffc;
    plan_kind[1] = BP_MEM32;
    plan_size[1] = 64'h8000_0000;
    plan_addr[1] = 64'h8000_0000;
    plan_pf[1] = 1'b0;
    err_phase = PH_CMD_REST;
    run_probe(8'h00, 5'h00, 3'h0, 16'h0, 8'h01, 1'b0);
    err_phase = PH_IDLE;
  endtask

  task automatic test_random(int src_pct, int snk_pct, int n_items, logic pressure);
    int pick, stop_at;
    logic [15:0] seg;
    logic [7:0]  hdr;
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    err_pct = 3;
    stop_at = item_count + n_items;
    if (pressure) hold_req = HoldOffCycles;
    while (item_count < stop_at) begin
      make_plan();
      pick = $urandom_range(0, 99);
      seg = 16'h0;
      hdr = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 6'h0, $urandom_range(0, 1) ? 1'b1 : 1'b0};
      if (pick < 5) seg = 16'($urandom_range(1, 16'hffff));
      else if (pick < 10) hdr = 8'($urandom_range(2, 255));
      run_probe(8'($urandom), 5'($urandom), 3'($urandom), seg, hdr,
                $urandom_range(0, 19) == 0);
    end
  endtask

  // Drive the result side ready, with random stalls and a long hold-off
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  // Check each result against the oldest expected one
  always @(posedge clk) begin
    result_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (access_q.size() == 0) begin
        $display("%0t: unexpected result kind %0d, expected none", $time, out_ch.kind);
        errors++;
      end else begin
        e = access_q.pop_front();
        check_field("kind", e.kind, out_ch.kind);
        check_field("cfg_address", e.cfg_address, out_ch.cfg_address);
        check_field("write_data", e.write_data, out_ch.write_data);
        check_field("bar_slot", e.bar_slot, out_ch.bar_slot);
        check_field("bar_address", e.bar_address, out_ch.bar_address);
        check_field("bar_size", e.bar_size, out_ch.bar_size);
        check_field("bar_is_memory", e.bar_is_memory, out_ch.bar_is_memory);
        check_field("bar_is_wide", e.bar_is_wide, out_ch.bar_is_wide);
        check_field("bar_prefetch", e.bar_prefetch, out_ch.bar_prefetch);
        check_field("status", e.status, out_ch.status);
        check_field("last", e.last, out_ch.last);
      end
    end
  end

  // Stop a run that makes no progress
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= NoAcceptLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_START;
    in_ch.bus_number = '0;
    in_ch.device_number = '0;
    in_ch.func_number = '0;
    in_ch.segment_number = '0;
    in_ch.header_kind = '0;
    in_ch.resp_data = '0;
    in_ch.resp_error = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(0, 0, 45, 1'b0);
    test_random(81, 0, 45, 1'b0);
    test_random(0, 81, 45, 1'b0);
    test_random(37, 37, 45, 1'b0);
    test_random(0, 0, 30, 1'b1);
    in_ch.valid = 1'b0;

    // Drain outstanding results, then allow the output queue to settle
    while (access_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
